// ===== design/spatial_dilemma_automaton_step_core_assert.svh =====
// assertion macros for the spatial dilemma automaton step core
// used by the top level; expects clk and rst_n in scope
`ifndef SPATIAL_DILEMMA_AUTOMATON_STEP_CORE_ASSERT_SVH
`define SPATIAL_DILEMMA_AUTOMATON_STEP_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SDAS_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SDAS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdas_pkg.sv =====
// shared types and constants for the spatial dilemma automaton step core
// no dependencies
package sdas_pkg;

  localparam int SIDE      = 64;
  localparam int ROW_W     = $clog2(SIDE);
  localparam int CELLS     = SIDE * SIDE;
  localparam int CNT_W     = 13;
  localparam int PAY_W     = 12;
  localparam int NCNT_W    = 4;
  localparam int SCORE_W   = PAY_W + NCNT_W;
  localparam int WIN       = 5;
  localparam int SWEEP_END = SIDE + 2;
  localparam int SEL_LAG   = 3;
  localparam int J_W       = $clog2(SWEEP_END + 1);
  localparam int REG_REWARD_RST = 256;
  localparam int REG_TEMPT_RST  = 461;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_GEN   = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_REWARD = 1'b0,
    REG_TEMPT  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_LOAD_REQ,
    ST_LOAD_DATA,
    ST_SWEEP,
    ST_STORE
  } state_t;

  // per-cycle control shared by every column cell
  typedef struct packed {
    logic load;
    logic rotate;
    logic unwind;
  } cell_ctrl_t;

endpackage

// ===== design/sdas_cell.sv =====
// one column cell of the window chain: five rows of strategy bits
// depends on sdas_pkg
module sdas_cell import sdas_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [WIN-1:0]   nb_next,
  input  logic [WIN-1:0]   nb_back,
  input  logic             load_bit,
  output logic [WIN-1:0]   col
);

  logic [WIN-1:0] col_r, col_nxt;

  // new row enters at the top, oldest drops out at bit zero
  always_comb begin
    if (ctrl.load) begin
      col_nxt = {load_bit, col_r[WIN-1:1]};
    end else if (ctrl.rotate) begin
      col_nxt = nb_next;
    end else if (ctrl.unwind) begin
      col_nxt = nb_back;
    end else begin
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  assign col = col_r;

endmodule

// ===== design/spatial_dilemma_automaton_step_core.sv =====
// top level of the spatial dilemma automaton step core
// depends on sdas_pkg, sdas_cell and spatial_dilemma_automaton_step_core_assert.svh
//
//  channel | signals                                        | accepted when
//  --------+------------------------------------------------+---------------------
//  in      | in_command in_row in_column in_strategy_in     | in_valid & in_ready
//  out     | out_strategy_out out_cooperator_count          | out_valid & out_ready
//  cfg     | cfg_index cfg_wdata                            | cfg_we
//
// a write or read item goes through the access state and then the result register.
// a generation loads the first five rows, then per row sweeps the column chain, stores
// the new row and loads one more row (none after the last row) before the result;
// the sweep moves the 64-cell column chain one column a cycle.
// reset is synchronous: grid reads as all defectors, count zero, payoffs to defaults.
// a new item is taken only once the previous result has left the output register.
`include "spatial_dilemma_automaton_step_core_assert.svh"
module spatial_dilemma_automaton_step_core import sdas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [ROW_W-1:0]   in_row,
  input  logic [ROW_W-1:0]   in_column,
  input  logic               in_strategy_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_strategy_out,
  output logic [CNT_W-1:0]   out_cooperator_count,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [PAY_W-1:0]   cfg_wdata
);

  // control registers
  state_t               state_r, state_nxt;
  logic                 bank_r, bank_nxt;
  logic [SIDE-1:0]      row_ok_r, row_ok_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;
  logic [CNT_W-1:0]     gen_cnt_r, gen_cnt_nxt;
  logic [ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]     ld_row_r, ld_row_nxt;
  logic [2:0]           ld_left_r, ld_left_nxt;
  logic [J_W-1:0]       jcnt_r, jcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_strat_r, out_strat_nxt;
  logic [PAY_W-1:0]     reward_r, temptation_r;

  // payload registers
  logic [1:0]           op_cmd_r;
  logic [ROW_W-1:0]     op_row_r, op_col_r;
  logic                 op_strat_r;
  logic [SIDE-1:0]      nrow_r, nrow_nxt;
  logic [SCORE_W-1:0]   sc_r [3][3];
  logic                 st_r [3][3];

  // grid memory, two banks of row words
  logic [SIDE-1:0]      grid_mem [2*SIDE];
  logic [ROW_W:0]       rd_addr, wr_addr;
  logic                 mem_we;
  logic [SIDE-1:0]      wr_data;
  logic [SIDE-1:0]      rd_data_r;
  logic                 rd_ok_r;

  logic                 accept;
  cell_ctrl_t           cell_ctrl;
  logic [WIN-1:0]       col [SIDE];
  logic [SIDE-1:0]      ld_word, rd_word;
  logic                 score_en;
  logic [SCORE_W-1:0]   new_sc [3];
  logic                 chosen;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_strategy_out     = out_strat_r;
  assign out_cooperator_count = live_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reward_r     <= PAY_W'(REG_REWARD_RST);
      temptation_r <= PAY_W'(REG_TEMPT_RST);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_REWARD: reward_r     <= cfg_wdata;
        REG_TEMPT:  temptation_r <= cfg_wdata;
        default:    reward_r     <= reward_r;
      endcase
    end
  end

  // memory ports
  assign rd_addr = (state_r == ST_IDLE) ? {bank_r, in_row} : {bank_r, ld_row_r};

  always_ff @(posedge clk) begin
    rd_data_r <= grid_mem[rd_addr];
    rd_ok_r   <= row_ok_r[rd_addr[ROW_W-1:0]];
    if (mem_we) begin
      grid_mem[wr_addr] <= wr_data;
    end
  end

  // rows never written since reset read as defectors
  assign rd_word = rd_ok_r ? rd_data_r : '0;
  // loaded rows enter pre-rotated so the column taps start one column back
  assign ld_word = {rd_word[SIDE-2:0], rd_word[SIDE-1]};

  // column cell chain
  for (genvar k = 0; k < SIDE; k++) begin : g_cell
    sdas_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .nb_next  (col[(k + 1) % SIDE]),
      .nb_back  (col[(k + SIDE - 2) % SIDE]),
      .load_bit (ld_word[k]),
      .col      (col[k])
    );
  end

  // scores of the three center cells in the tap column
  always_comb begin
    logic [NCNT_W-1:0] cnt;
    logic [PAY_W-1:0]  pay;
    for (int i = 0; i < 3; i++) begin
      cnt = '0;
      for (int rr = i; rr < i + 3; rr++) begin
        cnt = cnt + NCNT_W'(col[SIDE-1][rr]) + NCNT_W'(col[0][rr]) + NCNT_W'(col[1][rr]);
      end
      pay = col[0][i+1] ? reward_r : temptation_r;
      new_sc[i] = SCORE_W'(cnt) * SCORE_W'(pay);
    end
  end

  // scoring covers columns 63, 0..63 and 0 again, one per sweep cycle
  assign score_en = (state_r == ST_SWEEP) && (jcnt_r < J_W'(SWEEP_END));

  // three-column score window
  always_ff @(posedge clk) begin
    if (score_en) begin
      for (int i = 0; i < 3; i++) begin
        sc_r[0][i] <= sc_r[1][i];
        sc_r[1][i] <= sc_r[2][i];
        sc_r[2][i] <= new_sc[i];
        st_r[0][i] <= st_r[1][i];
        st_r[1][i] <= st_r[2][i];
        st_r[2][i] <= col[0][i+1];
      end
    end
  end

  // best neighbor in row-major window order, strictly greater wins
  always_comb begin
    logic [SCORE_W-1:0] best;
    best   = '0;
    chosen = st_r[1][1];
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (sc_r[dc][dr] > best) begin
          best   = sc_r[dc][dr];
          chosen = st_r[dc][dr];
        end
      end
    end
  end

  // next state and datapath control
  always_comb begin
    logic [SIDE-1:0] word;
    logic            old_bit;
    logic [J_W-1:0]  center;
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    row_ok_nxt    = row_ok_r;
    live_nxt      = live_r;
    gen_cnt_nxt   = gen_cnt_r;
    cur_row_nxt   = cur_row_r;
    ld_row_nxt    = ld_row_r;
    ld_left_nxt   = ld_left_r;
    jcnt_nxt      = jcnt_r;
    out_valid_nxt = out_valid_r;
    out_strat_nxt = out_strat_r;
    nrow_nxt      = nrow_r;
    mem_we        = 1'b0;
    wr_addr       = {bank_r, op_row_r};
    wr_data       = nrow_r;
    cell_ctrl     = '0;
    word          = rd_word;
    old_bit       = rd_word[op_col_r];
    center        = jcnt_r - J_W'(SEL_LAG);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_WRITE, CMD_READ: begin
              state_nxt = ST_ACCESS;
            end
            CMD_GEN: begin
              state_nxt   = ST_LOAD_REQ;
              ld_row_nxt  = ROW_W'(SIDE - 2);
              ld_left_nxt = 3'(WIN);
              cur_row_nxt = '0;
              gen_cnt_nxt = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_strat_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (op_cmd_r == CMD_WRITE) begin
          word[op_col_r]          = op_strat_r;
          mem_we                  = 1'b1;
          wr_data                 = word;
          row_ok_nxt[op_row_r]    = 1'b1;
          live_nxt                = live_r - CNT_W'(old_bit) + CNT_W'(op_strat_r);
          out_strat_nxt           = 1'b0;
        end else begin
          out_strat_nxt = old_bit;
        end
      end
      ST_LOAD_REQ: begin
        state_nxt = ST_LOAD_DATA;
      end
      ST_LOAD_DATA: begin
        cell_ctrl.load = 1'b1;
        ld_row_nxt     = ld_row_r + 1'b1;
        ld_left_nxt    = ld_left_r - 1'b1;
        if (ld_left_r == 3'd1) begin
          state_nxt = ST_SWEEP;
          jcnt_nxt  = '0;
        end else begin
          state_nxt = ST_LOAD_REQ;
        end
      end
      ST_SWEEP: begin
        cell_ctrl.rotate = score_en;
        if (jcnt_r >= J_W'(SEL_LAG)) begin
          nrow_nxt[center[ROW_W-1:0]] = chosen;
          gen_cnt_nxt = gen_cnt_r + CNT_W'(chosen);
        end
        if (jcnt_r == J_W'(SWEEP_END)) begin
          state_nxt = ST_STORE;
        end else begin
          jcnt_nxt = jcnt_r + 1'b1;
        end
      end
      ST_STORE: begin
        mem_we           = 1'b1;
        wr_addr          = {~bank_r, cur_row_r};
        wr_data          = nrow_r;
        cell_ctrl.unwind = 1'b1;
        if (cur_row_r == ROW_W'(SIDE - 1)) begin
          state_nxt     = ST_IDLE;
          bank_nxt      = ~bank_r;
          row_ok_nxt    = '1;
          live_nxt      = gen_cnt_r;
          out_valid_nxt = 1'b1;
          out_strat_nxt = 1'b0;
        end else begin
          state_nxt   = ST_LOAD_REQ;
          cur_row_nxt = cur_row_r + 1'b1;
          ld_left_nxt = 3'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      row_ok_r    <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      row_ok_r    <= row_ok_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencing and payload
  always_ff @(posedge clk) begin
    gen_cnt_r   <= gen_cnt_nxt;
    cur_row_r   <= cur_row_nxt;
    ld_row_r    <= ld_row_nxt;
    ld_left_r   <= ld_left_nxt;
    jcnt_r      <= jcnt_nxt;
    out_strat_r <= out_strat_nxt;
    nrow_r      <= nrow_nxt;
    if (accept) begin
      op_cmd_r   <= in_command;
      op_row_r   <= in_row;
      op_col_r   <= in_column;
      op_strat_r <= in_strategy_in;
    end
  end

  // checks
  `SDAS_SAME(a_no_take_while_full, out_valid_r, !in_ready, "item taken while result pending")
  `SDAS_SAME(a_count_bound, 1'b1, live_r <= CNT_W'(CELLS), "cooperator count above grid size")
  `SDAS_SAME(a_sweep_bound, state_r == ST_SWEEP, jcnt_r <= J_W'(SWEEP_END), "sweep overrun")
  `SDAS_NEXT(a_gen_starts, accept && in_command == CMD_GEN, state_r == ST_LOAD_REQ, "gen not started")

endmodule

// ===== test/tb_spatial_dilemma_automaton_step_core.sv =====
// testbench for the spatial dilemma automaton step core: random and directed items
// depends on sdas_pkg and spatial_dilemma_automaton_step_core; predicts results in a class
`timescale 1ns / 100ps

module tb_spatial_dilemma_automaton_step_core;
  import sdas_pkg::*;

  localparam int STALL_LIMIT = 40000;

  // grid predictor and queue of pending outcomes
  class dilemma_scoreboard;
    bit            grid [CELLS];
    bit [PAY_W-1:0] reward_q;
    bit [PAY_W-1:0] tempt_q;
    int unsigned   coop_total;
    bit            want_bit [$];
    bit [CNT_W-1:0] want_count [$];
    int            errors;

    function new();
      foreach (grid[k]) grid[k] = 1'b0;
      reward_q = PAY_W'(REG_REWARD_RST);
      tempt_q = PAY_W'(REG_TEMPT_RST);
      coop_total = 0;
      errors = 0;
    endfunction

    function int wrap(int p, int d);
      return (p + SIDE + d) % SIDE;
    endfunction

    // one synchronous generation over the torus
    function void advance_generation();
      int unsigned scores [CELLS];
      bit fresh [CELLS];
      int n;
      int best;
      int cand;
      bit pick;
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              n += grid[wrap(r, dr) * SIDE + wrap(c, dc)];
          scores[r * SIDE + c] = n * (grid[r * SIDE + c] ? reward_q : tempt_q);
        end
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++) begin
          best = 0;
          pick = grid[r * SIDE + c];
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++) begin
              cand = wrap(r, dr) * SIDE + wrap(c, dc);
              if (scores[cand] > best) begin
                best = scores[cand];
                pick = grid[cand];
              end
            end
          fresh[r * SIDE + c] = pick;
        end
      coop_total = 0;
      foreach (grid[k]) begin
        grid[k] = fresh[k];
        coop_total += fresh[k];
      end
    endfunction

    function void note_item(bit [1:0] cmd, bit [ROW_W-1:0] row, bit [ROW_W-1:0] col,
                            bit strat);
      int k;
      bit rd;
      k = row * SIDE + col;
      rd = 1'b0;
      if (cmd == CMD_WRITE) begin
        coop_total = coop_total - grid[k] + strat;
        grid[k] = strat;
      end else if (cmd == CMD_READ) begin
        rd = grid[k];
      end else if (cmd == CMD_GEN) begin
        advance_generation();
      end
      want_bit.push_back(rd);
      want_count.push_back(coop_total[CNT_W-1:0]);
    endfunction

    function void check_result(bit got_bit, bit [CNT_W-1:0] got_count);
      bit eb;
      bit [CNT_W-1:0] ec;
      if (want_bit.size() == 0) begin
        $display("%0t: unexpected result bit %0d count %0d", $time, got_bit, got_count);
        errors++;
        return;
      end
      eb = want_bit.pop_front();
      ec = want_count.pop_front();
      if (eb !== got_bit) begin
        $display("%0t: strategy_out expected %0d actual %0d", $time, eb, got_bit);
        errors++;
      end
      if (ec !== got_count) begin
        $display("%0t: cooperator_count expected %0d actual %0d", $time, ec, got_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_command = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic [ROW_W-1:0] in_column = '0;
  logic             in_strategy_in = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_strategy_out;
  logic [CNT_W-1:0] out_cooperator_count;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [PAY_W-1:0] cfg_wdata = '0;

  dilemma_scoreboard board = new();
  bit calm_phase = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  spatial_dilemma_automaton_step_core u_top (.*);

  always #2 clk = ~clk;

  // note accepted items and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_item(in_command, in_row, in_column, in_strategy_in);
    if (rst_n && out_valid && out_ready)
      board.check_result(out_strategy_out, out_cooperator_count);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver with random stalls
  always @(negedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else if (calm_phase)
      out_ready <= 1'b1;
    else
      out_ready <= ($urandom_range(99) >= 21);
  end

  // the leading falling edge keeps the drop of the previous item apart from this one
  task automatic send_item(bit [1:0] cmd, bit [ROW_W-1:0] row, bit [ROW_W-1:0] col,
                           bit strat);
    @(negedge clk);
    while (!calm_phase && $urandom_range(99) < 21) @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_row <= row;
    in_column <= col;
    in_strategy_in <= strat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, bit [PAY_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.reward_q = (idx == REG_REWARD) ? val : board.reward_q;
    board.tempt_q = (idx == REG_TEMPT) ? val : board.tempt_q;
  endtask

  task automatic drain();
    while (board.want_bit.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // mostly writes and reads into a small region, with occasional generations
  task automatic random_items(int count);
    bit [1:0] cmd;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      cmd = (pick < 55) ? CMD_WRITE : (pick < 92) ? CMD_READ : CMD_GEN;
      if ($urandom_range(3) == 0)
        send_item(cmd, ROW_W'($urandom), ROW_W'($urandom), 1'($urandom));
      else
        send_item(cmd, ROW_W'($urandom_range(8)), ROW_W'($urandom_range(8)),
                  $urandom_range(3) != 0);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: corners, reads, a single interior cell and generations
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_WRITE, 0, 0, 1);
    send_item(CMD_WRITE, 63, 63, 1);
    send_item(CMD_WRITE, 63, 0, 1);
    send_item(CMD_WRITE, 0, 63, 1);
    send_item(CMD_READ, 63, 63, 0);
    send_item(CMD_WRITE, 0, 0, 0);
    send_item(CMD_WRITE, 0, 0, 1);
    send_item(CMD_WRITE, 21, 42, 1);
    send_item(CMD_READ, 21, 42, 1);
    send_item(CMD_GEN, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_GEN, 63, 63, 1);
    drain();

    // zero payoffs: every cell keeps its strategy
    write_reg(REG_REWARD, 0);
    write_reg(REG_TEMPT, 0);
    send_item(CMD_WRITE, 5, 5, 1);
    send_item(CMD_GEN, 0, 0, 0);
    send_item(CMD_READ, 5, 5, 0);
    drain();

    // maximal payoffs with the receiver held off to fill the block
    write_reg(REG_REWARD, 4095);
    write_reg(REG_TEMPT, 4095);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      random_items(8);
    join
    drain();

    calm_phase = 1'b1;
    write_reg(REG_REWARD, 300);
    write_reg(REG_TEMPT, 200);
    random_items(30);
    drain();

    calm_phase = 1'b0;
    write_reg(REG_REWARD, PAY_W'(REG_REWARD_RST));
    write_reg(REG_TEMPT, PAY_W'(REG_TEMPT_RST));
    random_items(50);
    drain();

    write_reg(REG_REWARD, PAY_W'($urandom));
    write_reg(REG_TEMPT, PAY_W'($urandom));
    random_items(50);
    drain();

    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.want_bit.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
